>>> hw/rtl/m4mul_pkg.sv
package m4mul_pkg;

  // matrix geometry and number format
  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 2;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = DIM * DIM;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int ACC_W     = TERM_W + $clog2(DIM);

  // command codes
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_MULT   = 2'd2;

  // input transaction
  typedef struct packed {
    logic [1:0]               command;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;
  } cmd_t;

  // result transaction
  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] product_value;
    logic                     last_element;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic             mul_en;
    logic             acc_clear;
    logic             acc_add;
    logic             out_load;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/m4mul_ctrl.sv
module m4mul_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic [1:0]         command,
  output logic               cmd_ready,
  input  m4mul_pkg::sts_t    sts,
  output m4mul_pkg::ctl_t    ctl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [m4mul_pkg::IDX_W-1:0] IDX_LAST =
    m4mul_pkg::IDX_W'(m4mul_pkg::DIM - 1);

  logic [1:0]                  state, state_next;
  logic [m4mul_pkg::IDX_W-1:0] row, row_next;
  logic [m4mul_pkg::IDX_W-1:0] col, col_next;
  logic [m4mul_pkg::IDX_W-1:0] k, k_next;
  logic                        last;

  assign cmd_ready = (state == ST_IDLE);
  assign last      = (row == IDX_LAST) && (col == IDX_LAST);

  // next state and counters
  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    k_next     = k;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && command == m4mul_pkg::CMD_MULT) begin
          state_next = ST_MAC;
          row_next   = '0;
          col_next   = '0;
          k_next     = '0;
        end
      end
      ST_MAC: begin
        k_next = k + 1'b1;
        if (k == IDX_LAST) begin
          state_next = ST_DRAIN;
          k_next     = '0;
        end
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          if (last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_MAC;
            col_next   = col + 1'b1;
            if (col == IDX_LAST) begin
              col_next = '0;
              row_next = row + 1'b1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctl.mul_en    = (state == ST_MAC);
    ctl.acc_clear = (state == ST_MAC) && (k == '0);
    ctl.acc_add   = ((state == ST_MAC) && (k != '0)) || (state == ST_DRAIN);
    ctl.out_load  = (state == ST_EMIT) && sts.out_free;
    ctl.last      = last;
    ctl.row       = row;
    ctl.col       = col;
    ctl.k         = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      k     <= k_next;
    end
  end

endmodule

>>> hw/rtl/m4mul_dp.sv
module m4mul_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_en,
  input  m4mul_pkg::cmd_t    cmd_data,
  input  m4mul_pkg::ctl_t    ctl,
  output m4mul_pkg::sts_t    sts,
  output logic               res_valid,
  input  logic               res_ready,
  output m4mul_pkg::res_t    res_data
);

  localparam int DATA_W = m4mul_pkg::DATA_W;
  localparam int ACC_W  = m4mul_pkg::ACC_W;
  localparam int ADDR_W = m4mul_pkg::ADDR_W;

  logic [DATA_W-1:0] a_store [m4mul_pkg::DEPTH];
  logic [DATA_W-1:0] b_store [m4mul_pkg::DEPTH];

  logic [ADDR_W-1:0]                   wr_addr, a_addr, b_addr;
  logic                                in_range;
  logic signed [DATA_W-1:0]            a_rd, b_rd;
  logic signed [m4mul_pkg::PROD_W-1:0] product;
  logic signed [m4mul_pkg::TERM_W-1:0] term;
  logic signed [ACC_W-1:0]             acc;
  logic signed [ACC_W-1:0]             sat_max, sat_min;
  logic [DATA_W-1:0]                   sat_val;

  // element stores, written by load transactions
  assign in_range = (int'(cmd_data.row_index) < m4mul_pkg::DIM) &&
                    (int'(cmd_data.col_index) < m4mul_pkg::DIM);
  assign wr_addr  = ADDR_W'(int'(cmd_data.row_index) * m4mul_pkg::DIM +
                            int'(cmd_data.col_index));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < m4mul_pkg::DEPTH; i++) begin
        a_store[i] <= '0;
        b_store[i] <= '0;
      end
    end else if (load_en && in_range) begin
      if (cmd_data.command == m4mul_pkg::CMD_LOAD_A) begin
        a_store[wr_addr] <= cmd_data.element_value;
      end else if (cmd_data.command == m4mul_pkg::CMD_LOAD_B) begin
        b_store[wr_addr] <= cmd_data.element_value;
      end
    end
  end

  // operand fetch: A[row][k] and B[k][col]
  assign a_addr = ADDR_W'(int'(ctl.row) * m4mul_pkg::DIM + int'(ctl.k));
  assign b_addr = ADDR_W'(int'(ctl.k) * m4mul_pkg::DIM + int'(ctl.col));
  assign a_rd   = signed'(a_store[a_addr]);
  assign b_rd   = signed'(b_store[b_addr]);

  // registered product
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      product <= a_rd * b_rd;
    end
  end

  // drop fraction bits (floor) and accumulate exactly
  assign term = product[m4mul_pkg::PROD_W-1:m4mul_pkg::FRAC_BITS];

  always_ff @(posedge clk) begin
    if (ctl.acc_clear) begin
      acc <= '0;
    end else if (ctl.acc_add) begin
      acc <= acc + ACC_W'(term);
    end
  end

  // clamp to the 32-bit range
  assign sat_max = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  assign sat_min = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  always_comb begin
    if (acc > sat_max) begin
      sat_val = sat_max[DATA_W-1:0];
    end else if (acc < sat_min) begin
      sat_val = sat_min[DATA_W-1:0];
    end else begin
      sat_val = acc[DATA_W-1:0];
    end
  end

  // output register
  assign sts.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res_data.out_row       <= ctl.row;
      res_data.out_col       <= ctl.col;
      res_data.product_value <= signed'(sat_val);
      res_data.last_element  <= ctl.last;
    end
  end

endmodule

>>> hw/rtl/matrix4_multiplier.sv
// 4x4 signed Q16.16 matrix multiplier, A times B.
// Input channel (cmd_valid/cmd_ready/cmd_data): each transaction carries a
// command. Load A and load B write one element of the matching store;
// command 3 is dropped. A multiply transaction starts a product pass and
// emits 16 result transactions in row-major order, the last one flagged
// by last_element.
// Result channel (res_valid/res_ready/res_data): one output register.
// Each result element is formed by the MAC state, which runs one term per
// k through the single 32x32 multiplier, the DRAIN state, which adds the
// last term, and the EMIT state, which loads the output register.
// cmd_ready is low during a pass and goes high as the last result enters
// the output register, so loads may proceed while that result still waits.
// If the receiver stalls, the pass pauses with the finished element held
// until the output register frees up; nothing is dropped.
// Reset clears both stores to zero, empties the output register and
// returns the controller to idle.
module matrix4_multiplier (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  m4mul_pkg::cmd_t    cmd_data,
  output logic               res_valid,
  input  logic               res_ready,
  output m4mul_pkg::res_t    res_data
);

  m4mul_pkg::ctl_t ctl;
  m4mul_pkg::sts_t sts;
  logic            load_en;

  assign load_en = cmd_valid && cmd_ready;

  m4mul_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .command   (cmd_data.command),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  m4mul_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .load_en   (load_en),
    .cmd_data  (cmd_data),
    .ctl       (ctl),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // a multiply transaction makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_data.command == m4mul_pkg::CMD_MULT |=> !cmd_ready)
    else $error("input still ready after multiply accepted");

  // the flagged result is the bottom-right element
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.last_element |->
      res_data.out_row == m4mul_pkg::IDX_W'(m4mul_pkg::DIM - 1) &&
      res_data.out_col == m4mul_pkg::IDX_W'(m4mul_pkg::DIM - 1))
    else $error("last element flag on wrong position");

  // the output register is only loaded when it is free
  assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !res_valid || res_ready)
    else $error("output register overwritten");

  // a new pass never starts while an element is being formed
  assert property (@(posedge clk) disable iff (rst)
    ctl.mul_en |-> !cmd_ready)
    else $error("input ready during product pass");

endmodule
